// ----- rtl/core/voice_slot_allocator_unit_defines.svh -----
// Assertion macros shared by the voice slot allocator RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef VOICE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define VOICE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define VSA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VSA_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VSA_ASSERT(lbl, clk, rstn, prop, msg)
`define VSA_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/vsa_pkg.sv -----
// Types and constants for the voice slot allocator.
// No dependencies; used by every module of the block except vsa_ram.
`timescale 1ns / 1ps
package vsa_pkg;

    localparam int OP_W         = 3;
    localparam int PRIO_W       = 8;
    localparam int BUS_W        = 2;
    localparam int HANDLE_W     = 16;
    localparam int SLOT_FIELD_W = 3;
    localparam int QUOTA_W      = 4;
    localparam int MAX_QUOTA_REGS = 4;

    localparam logic [QUOTA_W-1:0] QUOTA_RESET = 4'd8;

    localparam logic [OP_W-1:0] OP_PLAY   = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd3;
    localparam logic [OP_W-1:0] OP_RETIRE = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [PRIO_W-1:0]       req_priority;
        logic [BUS_W-1:0]        req_bus;
        logic [HANDLE_W-1:0]     target_handle;
        logic [SLOT_FIELD_W-1:0] target_slot;
    } req_t;

    typedef struct packed {
        logic                    granted;
        logic [SLOT_FIELD_W-1:0] granted_slot;
        logic [HANDLE_W-1:0]     new_handle;
        logic                    was_stolen;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_scan;
        logic rd_last;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/core/vsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/vsa_ctrl.sv -----
// Sequencer for the voice slot allocator: load, table scan, commit.
// Depends on vsa_pkg and voice_slot_allocator_unit_defines.svh.
`timescale 1ns / 1ps
`include "voice_slot_allocator_unit_defines.svh"
module vsa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  vsa_pkg::sts_t  sts,
    output vsa_pkg::cmd_t  cmd
);

    vsa_pkg::state_t state_reg;
    vsa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vsa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vsa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sts.need_scan ? vsa_pkg::ST_SCAN : vsa_pkg::ST_COMMIT;
                end
            end
            vsa_pkg::ST_SCAN: begin
                if (sts.rd_last) begin
                    state_next = vsa_pkg::ST_LAST;
                end
            end
            vsa_pkg::ST_LAST: begin
                state_next = vsa_pkg::ST_COMMIT;
            end
            vsa_pkg::ST_COMMIT: begin
                // hold until the output register can take the result
                if (sts.out_free) begin
                    state_next = vsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.rd     = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            vsa_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            vsa_pkg::ST_SCAN: begin
                cmd.rd = 1'b1;
            end
            vsa_pkg::ST_LAST: begin
                cmd.rd = 1'b0;
            end
            vsa_pkg::ST_COMMIT: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    `VSA_ASSERT(a_scan_after_load, aclk, aresetn, ((state_reg == vsa_pkg::ST_IDLE) && s_valid && sts.need_scan) |=> (state_reg == vsa_pkg::ST_SCAN), "scanned request did not start a scan")
    `VSA_ASSERT(a_last_follows_read, aclk, aresetn, (state_reg == vsa_pkg::ST_LAST) |-> $past(cmd.rd), "final evaluation without a preceding read")
    `VSA_ASSERT(a_commit_holds, aclk, aresetn, ((state_reg == vsa_pkg::ST_COMMIT) && !sts.out_free) |=> (state_reg == vsa_pkg::ST_COMMIT), "commit left while output busy")

endmodule

// ----- rtl/core/vsa_dpath.sv -----
// Datapath for the voice slot allocator: slot table, scan accumulators, commit.
// Depends on vsa_pkg, vsa_ram and voice_slot_allocator_unit_defines.svh.
`timescale 1ns / 1ps
`include "voice_slot_allocator_unit_defines.svh"
module vsa_dpath #(
    parameter int NUM_SLOTS = 8,
    parameter int NUM_BUSES = 4,
    parameter int NUM_QUOTA = 4
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  vsa_pkg::req_t                             s_req,
    input  logic [NUM_QUOTA-1:0][vsa_pkg::QUOTA_W-1:0] quota,
    input  vsa_pkg::cmd_t                             cmd,
    output vsa_pkg::sts_t                             sts,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output vsa_pkg::rsp_t                             m_rsp
);

    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int CNT_W    = $clog2(NUM_SLOTS + 1);
    localparam int GS_W     = vsa_pkg::SLOT_FIELD_W;
    localparam int HANDLE_W = vsa_pkg::HANDLE_W;
    localparam int PRIO_W   = vsa_pkg::PRIO_W;
    localparam int BUS_W    = vsa_pkg::BUS_W;
    localparam int WORD_W   = HANDLE_W + PRIO_W + BUS_W;

    // slot flags
    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] paused_reg, paused_next;
    logic [NUM_SLOTS-1:0] hvalid_reg, hvalid_next;
    logic [HANDLE_W-1:0]  next_handle_reg, next_handle_next;

    // request and scan state
    vsa_pkg::req_t        req_reg, req_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [SLOT_W-1:0]    eval_idx_reg, eval_idx_next;
    logic                 pend_reg, pend_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 free_found_reg, free_found_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic                 steal_found_reg, steal_found_next;
    logic [SLOT_W-1:0]    steal_idx_reg, steal_idx_next;
    logic [PRIO_W-1:0]    low_reg, low_next;
    logic                 match_found_reg, match_found_next;
    logic [SLOT_W-1:0]    match_idx_reg, match_idx_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    vsa_pkg::rsp_t        rsp_reg, rsp_next;

    // table memory
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic [HANDLE_W-1:0]  rd_handle;
    logic [PRIO_W-1:0]    rd_prio;
    logic [BUS_W-1:0]     rd_bus;

    // commit decision
    logic [vsa_pkg::QUOTA_W-1:0] quota_sel;
    logic                 bus_ok;
    logic                 under_quota;
    logic                 take_free;
    logic                 take_steal;
    logic [SLOT_W-1:0]    play_slot;
    logic                 handle_hit;
    logic                 retire_ok;
    logic [SLOT_W-1:0]    retire_idx;
    logic [HANDLE_W-1:0]  handle_inc;

    vsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_handle = ram_rdata[WORD_W-1 -: HANDLE_W];
    assign rd_prio   = ram_rdata[BUS_W +: PRIO_W];
    assign rd_bus    = ram_rdata[BUS_W-1:0];

    assign sts.need_scan = (s_req.operation inside {vsa_pkg::OP_PLAY, vsa_pkg::OP_STOP,
                                                     vsa_pkg::OP_PAUSE, vsa_pkg::OP_RESUME});
    assign sts.rd_last   = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        quota_sel = '0;
        for (int b = 0; b < NUM_QUOTA; b++) begin
            if (int'(req_reg.req_bus) == b) begin
                quota_sel = quota[b];
            end
        end
    end

    assign bus_ok      = int'(req_reg.req_bus) < NUM_BUSES;
    assign under_quota = int'(cnt_reg) < int'(quota_sel);
    assign take_free   = bus_ok && under_quota && free_found_reg;
    assign take_steal  = bus_ok && !take_free && steal_found_reg;
    assign play_slot   = take_free ? free_idx_reg : steal_idx_reg;
    assign handle_hit  = (req_reg.target_handle != '0) && match_found_reg;
    assign retire_ok   = int'(req_reg.target_slot) < NUM_SLOTS;
    assign retire_idx  = SLOT_W'(req_reg.target_slot);
    assign handle_inc  = next_handle_reg + HANDLE_W'(1);

    // scan: request latch and accumulators
    always_comb begin
        req_next         = req_reg;
        idx_next         = idx_reg;
        eval_idx_next    = eval_idx_reg;
        pend_next        = cmd.rd;
        cnt_next         = cnt_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        steal_found_next = steal_found_reg;
        steal_idx_next   = steal_idx_reg;
        low_next         = low_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        if (cmd.load) begin
            req_next         = s_req;
            idx_next         = '0;
            cnt_next         = '0;
            free_found_next  = 1'b0;
            steal_found_next = 1'b0;
            match_found_next = 1'b0;
            low_next         = s_req.req_priority;
        end else begin
            if (cmd.rd) begin
                idx_next      = idx_reg + SLOT_W'(1);
                eval_idx_next = idx_reg;
            end
            // evaluate the entry read in the previous cycle
            if (pend_reg) begin
                if (active_reg[eval_idx_reg] && (rd_bus == req_reg.req_bus)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (rd_prio < low_reg) begin
                        low_next         = rd_prio;
                        steal_idx_next   = eval_idx_reg;
                        steal_found_next = 1'b1;
                    end
                end
                if (!active_reg[eval_idx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = eval_idx_reg;
                end
                if (hvalid_reg[eval_idx_reg] && !match_found_reg &&
                    (rd_handle == req_reg.target_handle)) begin
                    match_found_next = 1'b1;
                    match_idx_next   = eval_idx_reg;
                end
            end
        end
    end

    // commit: table update and result
    always_comb begin
        active_next      = active_reg;
        paused_next      = paused_reg;
        hvalid_next      = hvalid_reg;
        next_handle_next = next_handle_reg;
        ram_we           = 1'b0;
        ram_waddr        = play_slot;
        ram_wdata        = {next_handle_reg, req_reg.req_priority, req_reg.req_bus};
        rsp_next         = rsp_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
            rsp_next     = '0;
            case (req_reg.operation)
                vsa_pkg::OP_PLAY: begin
                    if (take_free || take_steal) begin
                        ram_we                 = 1'b1;
                        active_next[play_slot] = 1'b1;
                        paused_next[play_slot] = 1'b0;
                        hvalid_next[play_slot] = 1'b1;
                        // wrap and skip zero
                        next_handle_next  = (handle_inc == '0) ? HANDLE_W'(1) : handle_inc;
                        rsp_next.granted      = 1'b1;
                        rsp_next.granted_slot = GS_W'(play_slot);
                        rsp_next.new_handle   = next_handle_reg;
                        rsp_next.was_stolen   = take_steal;
                    end
                end
                vsa_pkg::OP_STOP: begin
                    if (handle_hit) begin
                        active_next[match_idx_reg] = 1'b0;
                        rsp_next.granted      = 1'b1;
                        rsp_next.granted_slot = GS_W'(match_idx_reg);
                    end
                end
                vsa_pkg::OP_PAUSE: begin
                    if (handle_hit) begin
                        paused_next[match_idx_reg] = 1'b1;
                        rsp_next.granted      = 1'b1;
                        rsp_next.granted_slot = GS_W'(match_idx_reg);
                    end
                end
                vsa_pkg::OP_RESUME: begin
                    if (handle_hit) begin
                        paused_next[match_idx_reg] = 1'b0;
                        rsp_next.granted      = 1'b1;
                        rsp_next.granted_slot = GS_W'(match_idx_reg);
                    end
                end
                vsa_pkg::OP_RETIRE: begin
                    if (retire_ok) begin
                        active_next[retire_idx] = 1'b0;
                        rsp_next.granted      = 1'b1;
                        rsp_next.granted_slot = GS_W'(retire_idx);
                    end
                end
                vsa_pkg::OP_CLEAR: begin
                    // drop every slot; cleared handles no longer match
                    active_next = '0;
                    paused_next = '0;
                    hvalid_next = '0;
                end
                default: begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= '0;
            paused_reg      <= '0;
            hvalid_reg      <= '0;
            next_handle_reg <= HANDLE_W'(1);
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            active_reg      <= active_next;
            paused_reg      <= paused_next;
            hvalid_reg      <= hvalid_next;
            next_handle_reg <= next_handle_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg         <= req_next;
        idx_reg         <= idx_next;
        eval_idx_reg    <= eval_idx_next;
        cnt_reg         <= cnt_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        steal_found_reg <= steal_found_next;
        steal_idx_reg   <= steal_idx_next;
        low_reg         <= low_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        rsp_reg         <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    `VSA_ASSERT(a_handle_nonzero, aclk, aresetn, (next_handle_reg != '0), "handle counter reached zero")
    `VSA_ASSERT(a_valid_from_commit, aclk, aresetn, $rose(m_valid_reg) |-> $past(cmd.commit), "result raised without a commit")
    `VSA_ASSERT(a_fail_fields_zero, aclk, aresetn, (m_valid_reg && !rsp_reg.granted) |-> ((rsp_reg.granted_slot == '0) && (rsp_reg.new_handle == '0)), "failed request carries slot or handle")

endmodule

// ----- rtl/core/voice_slot_allocator_unit.sv -----
// Voice slot allocator. Play, stop, pause and resume go from IDLE through SCAN and
// LAST to COMMIT; retire, clear and unused codes go from IDLE straight to COMMIT.
// A new request is taken only in IDLE, after the last one is committed. The scan reads one table
// entry per cycle through its single read port; a new request is taken while a result waits.
// Reset (aresetn, synchronous): quotas to 8, all slots free, handle counter 1;
// the table memory itself is not swept, entries are gated by per-slot flags.
`timescale 1ns / 1ps
module voice_slot_allocator_unit #(
    parameter int NUM_SLOTS = 8,
    parameter int NUM_BUSES = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vsa_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output vsa_pkg::rsp_t m_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int NUM_QUOTA = (NUM_BUSES < vsa_pkg::MAX_QUOTA_REGS) ?
                               NUM_BUSES : vsa_pkg::MAX_QUOTA_REGS;
    localparam int QUOTA_W   = vsa_pkg::QUOTA_W;

    logic [NUM_QUOTA-1:0][QUOTA_W-1:0] quota_reg, quota_next;
    logic [1:0]    reg_idx;
    logic          cfg_wr;
    vsa_pkg::cmd_t cmd;
    vsa_pkg::sts_t sts;

    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        quota_next = quota_reg;
        prdata     = '0;
        for (int q = 0; q < NUM_QUOTA; q++) begin
            if (int'(reg_idx) == q) begin
                prdata = 32'(quota_reg[q]);
                if (cfg_wr) begin
                    quota_next[q] = pwdata[QUOTA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < NUM_QUOTA; q++) begin
                quota_reg[q] <= vsa_pkg::QUOTA_RESET;
            end
        end else begin
            quota_reg <= quota_next;
        end
    end

    vsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vsa_dpath #(
        .NUM_SLOTS (NUM_SLOTS),
        .NUM_BUSES (NUM_BUSES),
        .NUM_QUOTA (NUM_QUOTA)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .quota   (quota_reg),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for voice_slot_allocator_unit: play, stop, pause, resume,
// retire and clear requests against an in-bench model of the slot table and quotas.
// Depends on vsa_pkg and the allocator RTL only.
`timescale 1ns / 1ps
module testbench;

    localparam int NUM_SLOTS        = 8;
    localparam int NUM_BUSES        = 4;
    localparam int REG_QUOTA_BUS0   = 0;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = NUM_SLOTS + 12;
    localparam longint CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS      = 100;

    localparam int OP_W         = vsa_pkg::OP_W;
    localparam int PRIO_W       = vsa_pkg::PRIO_W;
    localparam int BUS_W        = vsa_pkg::BUS_W;
    localparam int HANDLE_W     = vsa_pkg::HANDLE_W;
    localparam int SLOT_FIELD_W = vsa_pkg::SLOT_FIELD_W;
    localparam int QUOTA_W      = vsa_pkg::QUOTA_W;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    vsa_pkg::req_t s_req   = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    vsa_pkg::rsp_t m_rsp;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [3:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    // model of the slot table
    logic                 tbl_active [NUM_SLOTS];
    logic                 tbl_paused [NUM_SLOTS];
    logic [BUS_W-1:0]     tbl_bus    [NUM_SLOTS];
    logic [PRIO_W-1:0]    tbl_prio   [NUM_SLOTS];
    logic [HANDLE_W-1:0]  tbl_handle [NUM_SLOTS];
    logic [HANDLE_W-1:0]  handle_ctr;
    logic [QUOTA_W-1:0]   bus_quota  [NUM_BUSES];

    vsa_pkg::req_t request_queue [$];
    vsa_pkg::rsp_t outcomes_due  [$];
    int     error_count = 0;
    int     result_count = 0;
    longint cycle_count = 0;
    int     hold_seq = 0;

    // sender state
    int burst_left = 0;
    int gap_left   = 0;

    // receiver state
    int hold_seen  = 0;
    int hold_left  = 0;
    int mode_left  = 0;
    int stall_mode = 0;

    voice_slot_allocator_unit #(
        .NUM_SLOTS(NUM_SLOTS),
        .NUM_BUSES(NUM_BUSES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void clear_voice_table();
        int i;
        for (i = 0; i < NUM_SLOTS; i++) begin
            tbl_active[i] = 1'b0;
            tbl_paused[i] = 1'b0;
            tbl_bus[i]    = '0;
            tbl_prio[i]   = '0;
            tbl_handle[i] = '0;
        end
    endfunction

    // Apply one request to the table model and return the outcome it yields.
    function automatic vsa_pkg::rsp_t allocate_voice(input vsa_pkg::req_t r);
        vsa_pkg::rsp_t     o;
        int                i;
        int                hit;
        int                n_on_bus;
        logic [PRIO_W-1:0] lowest;
        o   = '0;
        hit = -1;
        case (r.operation)
            vsa_pkg::OP_PLAY: begin
                if (int'(r.req_bus) < NUM_BUSES) begin
                    n_on_bus = 0;
                    for (i = 0; i < NUM_SLOTS; i++)
                        if (tbl_active[i] && tbl_bus[i] == r.req_bus)
                            n_on_bus++;
                    if (n_on_bus < int'(bus_quota[r.req_bus]))
                        for (i = 0; i < NUM_SLOTS; i++)
                            if (!tbl_active[i] && hit < 0)
                                hit = i;
                    // quota reached or table full: steal strictly lower priority
                    if (hit < 0) begin
                        lowest = r.req_priority;
                        for (i = 0; i < NUM_SLOTS; i++)
                            if (tbl_active[i] && tbl_bus[i] == r.req_bus &&
                                    tbl_prio[i] < lowest) begin
                                lowest = tbl_prio[i];
                                hit    = i;
                            end
                    end
                end
                if (hit >= 0) begin
                    o.granted      = 1'b1;
                    o.granted_slot = SLOT_FIELD_W'(hit);
                    o.new_handle   = handle_ctr;
                    o.was_stolen   = tbl_active[hit];
                    tbl_handle[hit] = handle_ctr;
                    handle_ctr      = handle_ctr + HANDLE_W'(1);
                    if (handle_ctr == '0)
                        handle_ctr = HANDLE_W'(1);
                    tbl_prio[hit]   = r.req_priority;
                    tbl_bus[hit]    = r.req_bus;
                    tbl_active[hit] = 1'b1;
                    tbl_paused[hit] = 1'b0;
                end
            end
            vsa_pkg::OP_STOP, vsa_pkg::OP_PAUSE, vsa_pkg::OP_RESUME: begin
                if (r.target_handle != '0)
                    for (i = 0; i < NUM_SLOTS; i++)
                        if (hit < 0 && tbl_handle[i] == r.target_handle)
                            hit = i;
                if (hit >= 0) begin
                    if (r.operation == vsa_pkg::OP_STOP)
                        tbl_active[hit] = 1'b0;
                    else if (r.operation == vsa_pkg::OP_PAUSE)
                        tbl_paused[hit] = 1'b1;
                    else
                        tbl_paused[hit] = 1'b0;
                    o.granted      = 1'b1;
                    o.granted_slot = SLOT_FIELD_W'(hit);
                end
            end
            vsa_pkg::OP_RETIRE: begin
                if (int'(r.target_slot) < NUM_SLOTS) begin
                    tbl_active[r.target_slot] = 1'b0;
                    o.granted      = 1'b1;
                    o.granted_slot = r.target_slot;
                end
            end
            vsa_pkg::OP_CLEAR: clear_voice_table();
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTS)
            $display("[%0t] result %0d: %s got %0h want %0h",
                     $realtime, result_count, what, got, want);
        error_count++;
    endtask

    task automatic send_request(input vsa_pkg::req_t r);
        @(negedge aclk);
        while (request_queue.size() >= 2)
            @(negedge aclk);
        request_queue.push_back(r);
    endtask

    task automatic wait_until_idle();
        do
            @(negedge aclk);
        while (request_queue.size() != 0 || s_valid || outcomes_due.size() != 0);
    endtask

    task automatic write_quota(input int bus, input logic [QUOTA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * (REG_QUOTA_BUS0 + bus));
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bus_quota[bus] = value;
    endtask

    task automatic check_quota_readback(input int bus);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 4'(4 * (REG_QUOTA_BUS0 + bus));
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        if (prdata !== 32'(bus_quota[bus]))
            report_mismatch("quota readback", prdata, 32'(bus_quota[bus]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // sender: bursts of random length, random gaps in between
    always @(posedge aclk) begin
        if (s_valid && s_ready)
            outcomes_due.push_back(allocate_voice(s_req));
        if (s_valid && !s_ready) begin
            // hold the request until taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
            s_valid <= 1'b1;
            s_req   <= request_queue.pop_front();
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                gap_left   = $urandom_range(1, 10);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 6);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: stall modes that change now and then, plus the long hold-off
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD_CYCLES;
            m_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 1) == 0);
                default: m_ready <= (cycle_count % 3) != 0;
            endcase
        end
    end

    always @(posedge aclk) begin
        vsa_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch("unrequested result", 32'(m_rsp), '0);
            end else begin
                want = outcomes_due.pop_front();
                if (m_rsp.granted !== want.granted)
                    report_mismatch("granted", 32'(m_rsp.granted), 32'(want.granted));
                if (m_rsp.granted_slot !== want.granted_slot)
                    report_mismatch("granted_slot", 32'(m_rsp.granted_slot),
                                    32'(want.granted_slot));
                if (m_rsp.new_handle !== want.new_handle)
                    report_mismatch("new_handle", 32'(m_rsp.new_handle),
                                    32'(want.new_handle));
                if (m_rsp.was_stolen !== want.was_stolen)
                    report_mismatch("was_stolen", 32'(m_rsp.was_stolen),
                                    32'(want.was_stolen));
            end
            result_count++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_directed_basics();
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,    8'h00, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,    8'hFF, 2'd3, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,    8'h80, 2'd1, 16'h0000, 3'd0});
        // handle zero never matches
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_STOP,    8'h00, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PAUSE,   8'hFF, 2'd3, 16'h0000, 3'd7});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_RESUME,  8'h00, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_STOP,    8'h00, 2'd0, 16'hFFFF, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PAUSE,   8'h00, 2'd0, 16'h0001, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_RESUME,  8'h00, 2'd0, 16'h0001, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_STOP,    8'h00, 2'd0, 16'h0003, 3'd0});
        // a stopped voice keeps its handle and still matches
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_STOP,    8'h00, 2'd0, 16'h0003, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_RETIRE,  8'h00, 2'd0, 16'h0000, 3'd7});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_RETIRE,  8'h00, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{OP_SPARE_6,          8'hFF, 2'd3, 16'hFFFF, 3'd7});
        send_request(vsa_pkg::req_t'{OP_SPARE_7,          8'hFF, 2'd3, 16'hFFFF, 3'd7});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,    8'hC8, 2'd2, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PAUSE,   8'h00, 2'd0, 16'h0002, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_CLEAR,   8'hFF, 2'd3, 16'hFFFF, 3'd7});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_STOP,    8'h00, 2'd0, 16'h0001, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,    8'h01, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_RETIRE,  8'h00, 2'd0, 16'h0000, 3'd0});
    endtask

    task automatic test_quota_and_stealing();
        int b;
        int n;
        wait_until_idle();
        write_quota(0, 4'd2);
        write_quota(1, 4'd0);
        write_quota(2, 4'd8);
        write_quota(3, 4'd1);
        for (b = 0; b < NUM_BUSES; b++)
            check_quota_readback(b);
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_CLEAR, 8'h00, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd10, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd20, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd15, 2'd0, 16'h0000, 3'd0});
        // equal priority is not low enough to steal
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd15, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd40, 2'd0, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd5,  2'd1, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd7,  2'd3, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd7,  2'd3, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd8,  2'd3, 16'h0000, 3'd0});
        // fill the table, then steal; of equally low victims the lowest slot is taken
        for (n = 0; n < 6; n++)
            send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY, 8'd30, 2'd2, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd31, 2'd2, 16'h0000, 3'd0});
        send_request(vsa_pkg::req_t'{vsa_pkg::OP_PLAY,  8'd31, 2'd2, 16'h0000, 3'd0});
    endtask

    task automatic test_random_traffic(input int n_items);
        vsa_pkg::req_t r;
        int            pick;
        repeat (n_items) begin
            r    = vsa_pkg::req_t'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                r.operation = vsa_pkg::OP_PLAY;
                if ($urandom_range(0, 1) == 0)
                    r.req_priority = PRIO_W'($urandom_range(0, 7));
            end else if (pick < 75) begin
                r.operation = (pick < 55) ? vsa_pkg::OP_STOP :
                              (pick < 65) ? vsa_pkg::OP_PAUSE : vsa_pkg::OP_RESUME;
                if ($urandom_range(0, 9) < 7)
                    r.target_handle = tbl_handle[$urandom_range(0, NUM_SLOTS - 1)];
                else
                    r.target_handle = handle_ctr - HANDLE_W'($urandom_range(1, 12));
            end else if (pick < 85) begin
                r.operation = vsa_pkg::OP_RETIRE;
            end else if (pick < 87) begin
                r.operation = vsa_pkg::OP_CLEAR;
            end else if (pick < 94) begin
                // stray handle
                pick        = $urandom_range(0, 2);
                r.operation = (pick == 0) ? vsa_pkg::OP_STOP :
                              (pick == 1) ? vsa_pkg::OP_PAUSE : vsa_pkg::OP_RESUME;
            end else begin
                r.operation = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
            end
            send_request(r);
        end
    endtask

    task automatic test_full_backpressure();
        hold_seq++;
        test_random_traffic(40);
        wait_until_idle();
    endtask

    initial begin
        int phase;
        int b;
        for (b = 0; b < NUM_BUSES; b++)
            bus_quota[b] = vsa_pkg::QUOTA_RESET;
        handle_ctr = HANDLE_W'(1);
        clear_voice_table();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_basics();
        test_quota_and_stealing();
        test_full_backpressure();
        for (phase = 0; phase < 6; phase++) begin
            wait_until_idle();
            for (b = 0; b < NUM_BUSES; b++) begin
                if (phase == 0)
                    write_quota(b, 4'd8);
                else if (phase == 1)
                    write_quota(b, (b % 2 == 0) ? 4'd0 : 4'd1);
                else
                    write_quota(b, QUOTA_W'($urandom_range(0, 8)));
            end
            test_random_traffic(300);
        end

        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- voice_slot_allocator_unit.f -----
+incdir+rtl/core
rtl/core/vsa_pkg.sv
rtl/core/vsa_ram.sv
rtl/core/vsa_ctrl.sv
rtl/core/vsa_dpath.sv
rtl/core/voice_slot_allocator_unit.sv
test/testbench.sv
